@@ rtl/tlta_pkg.sv @@
// Package for the two-lane traffic automaton.
// Shared types, cell codes, command codes and grid size constants.
// No dependencies.
`timescale 1ns / 1ps

package tlta_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 7;
  localparam int ROW_BITS   = 2 * MAX_WIDTH;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_UP    = 2'd1;
  localparam logic [1:0] CELL_RIGHT = 2'd2;
  localparam logic [1:0] CELL_ODD   = 2'd3;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [1:0]       cell_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  read_state;
    logic [15:0] epoch_count;
    logic        coord_error;
  } result_t;

endpackage

@@ rtl/tlta_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tlta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tlta_cell.sv @@
// One cell of the row update: next state from own and neighbor states.
// Depends on tlta_pkg.
`timescale 1ns / 1ps

module tlta_cell (
  input  logic [1:0] self_s,
  input  logic [1:0] up_s,
  input  logic [1:0] down_s,
  input  logic [1:0] left_s,
  input  logic [1:0] right_s,
  input  logic       even,
  input  logic       active,
  output logic [1:0] next_s
);

  always_comb begin
    next_s = self_s;
    if (active) begin
      if (self_s == tlta_pkg::CELL_UP) begin
        if (even && up_s == tlta_pkg::CELL_EMPTY) next_s = tlta_pkg::CELL_EMPTY;
      end else if (self_s == tlta_pkg::CELL_RIGHT) begin
        if (!even && right_s == tlta_pkg::CELL_EMPTY) next_s = tlta_pkg::CELL_EMPTY;
      end else if (even) begin
        if (down_s == tlta_pkg::CELL_UP) next_s = tlta_pkg::CELL_UP;
      end else begin
        if (left_s == tlta_pkg::CELL_RIGHT) next_s = tlta_pkg::CELL_RIGHT;
      end
    end
  end

endmodule

@@ rtl/two_lane_traffic_automaton.sv @@
// Top level of the two-lane traffic automaton (toroidal traffic grid).
// Depends on tlta_pkg, tlta_ram and tlta_cell.
`timescale 1ns / 1ps
//
//  channel   handshake            payload
//  command   start / busy         cmd    (mode, col, row, cell_value)
//  result    done (strobe)        result (read_state, epoch_count, coord_error)
//  config    cfg_we               cfg_index, cfg_wdata
//
// Clear and any out-of-range write or read: result in the cycle after the word
// is taken. Read: the row is read while idle and the cell picked in S_READ.
// Write: read-modify-write of one row. Step: the single RAM read port streams
// one row per cycle through a three-row window and a row of cells.
// Reset empties the grid at once through per-row valid bits; no clearing pass.
// Results are not held: done is high for one cycle per accepted word.

module two_lane_traffic_automaton (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  tlta_pkg::cmd_t                     cmd,
  output logic                               done,
  output tlta_pkg::result_t                  result,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [tlta_pkg::SIZE_W-1:0]        cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_WRITE, S_READ, S_STEP} state_t;

  localparam int RW = tlta_pkg::ROW_W;
  localparam int CW = tlta_pkg::COL_W;
  localparam int SW = tlta_pkg::SIZE_W;
  localparam int NB = tlta_pkg::ROW_BITS;
  localparam int NC = tlta_pkg::MAX_WIDTH;

  state_t                 state;
  logic [SW-1:0]          grid_width, grid_height;
  logic [15:0]            epoch;
  logic [tlta_pkg::MAX_HEIGHT-1:0] row_valid;
  tlta_pkg::cmd_t         cmd_q;

  // step pipeline: issue, arrival into window, write back
  logic [SW-1:0]          iss_k;
  logic                   rd_vld, rd_pseudo, rd_first, rv_q;
  logic [SW-1:0]          arr;
  logic                   win_ready;
  logic [RW-1:0]          wr_row;
  logic [NB-1:0]          up_row, mid_row, dn_row, first_row;

  logic [SW-1:0]          eff_w, eff_h;
  logic [RW-1:0]          raddr, waddr;
  logic [NB-1:0]          rdata, row_data, wdata, new_row, mod_row;
  logic                   we, accept, coord_ok, even;

  // clamp sizes: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    eff_w = grid_width;
    if (grid_width == '0) eff_w = SW'(1);
    else if (grid_width > SW'(tlta_pkg::MAX_WIDTH)) eff_w = SW'(tlta_pkg::MAX_WIDTH);
    eff_h = grid_height;
    if (grid_height == '0) eff_h = SW'(1);
    else if (grid_height > SW'(tlta_pkg::MAX_HEIGHT)) eff_h = SW'(tlta_pkg::MAX_HEIGHT);
  end

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign coord_ok = ({1'b0, cmd.col} < eff_w) && ({1'b0, cmd.row} < eff_h);
  assign even     = !epoch[0];

  // rows never written since reset or clear read as empty
  assign row_data = rv_q ? rdata : '0;

  // read address: command row when idle, else the step sequence h-1, 0, 1, .., h-1
  always_comb begin
    if (state == S_IDLE) raddr = cmd.row;
    else if (iss_k == '0) raddr = RW'(eff_h - SW'(1));
    else raddr = RW'(iss_k - SW'(1));
  end

  tlta_ram #(.WIDTH(NB), .DEPTH(tlta_pkg::MAX_HEIGHT)) u_grid (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // the row of cells: each column sees its window neighbors, wrapping at eff_w
  logic [1:0] mid_cells [NC];
  for (genvar c = 0; c < NC; c++) begin : g_unpack
    assign mid_cells[c] = mid_row[2*c +: 2];
  end

  for (genvar c = 0; c < NC; c++) begin : g_cells
    logic [1:0] left_s, right_s;
    if (c == 0) begin : g_l0
      assign left_s = mid_cells[CW'(eff_w - SW'(1))];
    end else begin : g_ln
      assign left_s = mid_cells[c-1];
    end
    if (c == NC-1) begin : g_rl
      assign right_s = mid_cells[0];
    end else begin : g_rn
      assign right_s = (SW'(c+1) >= eff_w) ? mid_cells[0] : mid_cells[c+1];
    end
    tlta_cell u_cell (
      .self_s (mid_cells[c]),
      .up_s   (up_row[2*c +: 2]),
      .down_s (dn_row[2*c +: 2]),
      .left_s (left_s),
      .right_s(right_s),
      .even   (even),
      .active (SW'(c) < eff_w),
      .next_s (new_row[2*c +: 2])
    );
    // single-cell write merge; a written 3 is stored as empty
    assign mod_row[2*c +: 2] = (CW'(c) == cmd_q.col) ?
      ((cmd_q.cell_value == tlta_pkg::CELL_ODD) ? tlta_pkg::CELL_EMPTY : cmd_q.cell_value) :
      row_data[2*c +: 2];
  end

  always_comb begin
    we    = 1'b0;
    waddr = cmd_q.row;
    wdata = mod_row;
    if (state == S_WRITE) begin
      we = 1'b1;
    end else if (state == S_STEP && win_ready) begin
      we    = 1'b1;
      waddr = wr_row;
      wdata = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      grid_width  <= SW'(64);
      grid_height <= SW'(64);
      epoch       <= '0;
      row_valid   <= '0;
      done        <= 1'b0;
      rd_vld      <= 1'b0;
      win_ready   <= 1'b0;
      iss_k       <= '0;
      arr         <= '0;
    end else begin
      done <= 1'b0;
      rv_q <= row_valid[raddr];

      if (cfg_we) begin
        if (cfg_index == tlta_pkg::REG_GRID_WIDTH) grid_width <= cfg_wdata;
        else grid_height <= cfg_wdata;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q                     <= cmd;
            result.read_state         <= tlta_pkg::CELL_EMPTY;
            result.coord_error        <= 1'b0;
            result.epoch_count        <= epoch;
            iss_k                     <= '0;
            arr                       <= '0;
            rd_vld                    <= 1'b0;
            win_ready                 <= 1'b0;
            case (cmd.mode)
              tlta_pkg::MODE_CLEAR: begin
                // drop every row at once
                row_valid          <= '0;
                epoch              <= '0;
                result.epoch_count <= '0;
                done               <= 1'b1;
              end
              tlta_pkg::MODE_STEP: state <= S_STEP;
              default: begin
                if (!coord_ok) begin
                  result.coord_error <= 1'b1;
                  done               <= 1'b1;
                end else if (cmd.mode == tlta_pkg::MODE_WRITE) begin
                  state <= S_WRITE;
                end else begin
                  state <= S_READ;
                end
              end
            endcase
          end
        end

        S_WRITE: begin
          row_valid[cmd_q.row] <= 1'b1;
          done                 <= 1'b1;
          state                <= S_IDLE;
        end

        S_READ: begin
          result.read_state <= row_data[2*cmd_q.col +: 2];
          done              <= 1'b1;
          state             <= S_IDLE;
        end

        S_STEP: begin
          // issue h+1 reads, then one pseudo read that replays old row 0
          if (iss_k <= eff_h + SW'(1)) begin
            rd_vld    <= 1'b1;
            rd_pseudo <= (iss_k == eff_h + SW'(1));
            rd_first  <= (iss_k == SW'(1));
            iss_k     <= iss_k + SW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          // advance the three-row window
          if (rd_vld) begin
            up_row  <= mid_row;
            mid_row <= dn_row;
            dn_row  <= rd_pseudo ? first_row : row_data;
            if (rd_first) first_row <= row_data;
            arr     <= arr + SW'(1);
            wr_row  <= RW'(arr - SW'(2));
          end
          win_ready <= rd_vld && (arr >= SW'(2));
          // write back; the last row ends the step
          if (win_ready) begin
            row_valid[wr_row] <= 1'b1;
            if ({1'b0, wr_row} == eff_h - SW'(1)) begin
              epoch              <= epoch + 16'd1;
              result.epoch_count <= epoch + 16'd1;
              done               <= 1'b1;
              rd_vld             <= 1'b0;
              win_ready          <= 1'b0;
              state              <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/tlta_checker.sv @@
// Port-level checker for the traffic automaton, bound to the top level.
// Depends on tlta_pkg and two_lane_traffic_automaton.
`timescale 1ns / 1ps

module tlta_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input tlta_pkg::cmd_t    cmd,
  input logic              done,
  input tlta_pkg::result_t result
);

  // an accepted word either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted word neither answered nor busy");

  // leaving busy always delivers the result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // an error word never carries read data
  a_err_read: assert property (@(posedge clk) disable iff (rst)
    (done && result.coord_error) |-> (result.read_state == tlta_pkg::CELL_EMPTY))
    else $error("error result with read data");

  // a clear answers at once with a zero epoch
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.mode == tlta_pkg::MODE_CLEAR) |=>
      (done && result.epoch_count == 16'd0))
    else $error("clear did not zero the epoch");

endmodule

bind two_lane_traffic_automaton tlta_checker u_tlta_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done),
  .result(result)
);
